// ----- hdl/contact_restitution_kick_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the contact restitution kick block.
// They compile to nothing when synthesising.
// ----------------------------------------------------------------------------
`ifndef CONTACT_RESTITUTION_KICK_DEFINES_SVH
`define CONTACT_RESTITUTION_KICK_DEFINES_SVH
`ifndef SYNTHESIS
`define CRK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CRK_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRK_ASSERT(label, clk, rst, prop, msg)
`define CRK_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hdl/crk_pkg.sv -----
// ----------------------------------------------------------------------------
// crk_pkg
// Shared types and constants of the contact restitution kick block.
// ----------------------------------------------------------------------------
`default_nettype none
package crk_pkg;
   localparam int QW = 32;
   localparam logic signed [QW-1:0] KICK_Q = 32'sd68813;
   localparam logic signed [QW-1:0] DAMP_Q = 32'sd58982;
   localparam logic [7:0] THRESH_MIN = 8'd10;
   localparam int INTEN_MAX = 27;
   localparam int PROG_LEN = 64;
   localparam int PC_W = $clog2(PROG_LEN);

   // Register file of the sequencer.
   typedef enum logic [4:0] {
      R_VX, R_VY, R_VZ, R_WX, R_WY, R_WZ, R_NX, R_NY, R_NZ,
      R_D, R_S, R_TX, R_TY, R_TZ, R_UX, R_UY, R_UZ,
      R_AX, R_AY, R_AZ, R_BX, R_BY, R_BZ, R_C0, R_C1, R_C2,
      R_K, R_DAMP, R_ZERO
   } reg_type;

   // Phase of a program step, which decides whether it runs.
   typedef enum logic [1:0] {
      PH_ALL, PH_HIT, PH_DAMP, PH_FOLD
   } phase_type;

   // One step: acc = (add_dst ? dst : clear ? 0 : acc) +/- floor(a*b); saturate, optional store.
   typedef struct packed {
      phase_type ph;
      reg_type   a;
      reg_type   b;
      logic      clr;
      logic      sub;
      logic      store;
      reg_type   dst;
      logic      add_dst; // acc starts from dst (velocity minus product)
   } step_type;

   localparam int NSTEP = 58;

   function automatic step_type mk(phase_type ph, reg_type a, reg_type b,
                                   logic clr, logic sub, logic st, reg_type dst,
                                   logic ad);
      step_type s;
      s.ph = ph; s.a = a; s.b = b; s.clr = clr; s.sub = sub;
      s.store = st; s.dst = dst; s.add_dst = ad;
      return s;
   endfunction

   function automatic step_type prog(input logic [PC_W-1:0] pc);
      step_type s;
      s = mk(PH_ALL, R_ZERO, R_ZERO, 1'b1, 1'b0, 1'b0, R_ZERO, 1'b0);
      unique case (pc)
         6'd0:  s = mk(PH_ALL, R_NX, R_VX, 1, 0, 0, R_D, 0);
         6'd1:  s = mk(PH_ALL, R_NY, R_VY, 0, 0, 0, R_D, 0);
         6'd2:  s = mk(PH_ALL, R_NZ, R_VZ, 0, 0, 1, R_D, 0);
         6'd3:  s = mk(PH_ALL, R_K, R_D, 1, 0, 1, R_S, 0);
         6'd4:  s = mk(PH_ALL, R_S, R_NX, 0, 1, 1, R_VX, 1);
         6'd5:  s = mk(PH_ALL, R_S, R_NY, 0, 1, 1, R_VY, 1);
         6'd6:  s = mk(PH_ALL, R_S, R_NZ, 0, 1, 1, R_VZ, 1);
         6'd7:  s = mk(PH_HIT, R_VX, R_DAMP, 1, 0, 1, R_VX, 0);
         6'd8:  s = mk(PH_HIT, R_VY, R_DAMP, 1, 0, 1, R_VY, 0);
         6'd9:  s = mk(PH_HIT, R_VZ, R_DAMP, 1, 0, 1, R_VZ, 0);
         6'd10: s = mk(PH_DAMP, R_VX, R_DAMP, 1, 0, 1, R_VX, 0);
         6'd11: s = mk(PH_DAMP, R_VY, R_DAMP, 1, 0, 1, R_VY, 0);
         6'd12: s = mk(PH_DAMP, R_VZ, R_DAMP, 1, 0, 1, R_VZ, 0);
         6'd13: s = mk(PH_FOLD, R_NX, R_NY, 1, 0, 0, R_TX, 0);
         6'd14: s = mk(PH_FOLD, R_NZ, R_NZ, 0, 1, 1, R_TX, 0);
         6'd15: s = mk(PH_FOLD, R_NY, R_NZ, 1, 0, 0, R_TY, 0);
         6'd16: s = mk(PH_FOLD, R_NX, R_NX, 0, 1, 1, R_TY, 0);
         6'd17: s = mk(PH_FOLD, R_NX, R_NZ, 1, 0, 0, R_TZ, 0);
         6'd18: s = mk(PH_FOLD, R_NY, R_NY, 0, 1, 1, R_TZ, 0);
         6'd19: s = mk(PH_FOLD, R_NY, R_TZ, 1, 0, 0, R_UX, 0);
         6'd20: s = mk(PH_FOLD, R_NZ, R_TY, 0, 1, 1, R_UX, 0);
         6'd21: s = mk(PH_FOLD, R_NZ, R_TX, 1, 0, 0, R_UY, 0);
         6'd22: s = mk(PH_FOLD, R_NX, R_TZ, 0, 1, 1, R_UY, 0);
         6'd23: s = mk(PH_FOLD, R_NX, R_TY, 1, 0, 0, R_UZ, 0);
         6'd24: s = mk(PH_FOLD, R_NY, R_TX, 0, 1, 1, R_UZ, 0);
         6'd25: s = mk(PH_FOLD, R_NX, R_NX, 1, 0, 0, R_AX, 0);
         6'd26: s = mk(PH_FOLD, R_TX, R_NY, 0, 0, 0, R_AX, 0);
         6'd27: s = mk(PH_FOLD, R_UX, R_NZ, 0, 0, 1, R_AX, 0);
         6'd28: s = mk(PH_FOLD, R_NY, R_NX, 1, 0, 0, R_AY, 0);
         6'd29: s = mk(PH_FOLD, R_TY, R_NY, 0, 0, 0, R_AY, 0);
         6'd30: s = mk(PH_FOLD, R_UY, R_NZ, 0, 0, 1, R_AY, 0);
         6'd31: s = mk(PH_FOLD, R_NZ, R_NX, 1, 0, 0, R_AZ, 0);
         6'd32: s = mk(PH_FOLD, R_TZ, R_NY, 0, 0, 0, R_AZ, 0);
         6'd33: s = mk(PH_FOLD, R_UZ, R_NZ, 0, 0, 1, R_AZ, 0);
         6'd34: s = mk(PH_FOLD, R_NX, R_WX, 1, 0, 0, R_BX, 0);
         6'd35: s = mk(PH_FOLD, R_TX, R_WY, 0, 0, 0, R_BX, 0);
         6'd36: s = mk(PH_FOLD, R_UX, R_WZ, 0, 0, 1, R_BX, 0);
         6'd37: s = mk(PH_FOLD, R_NY, R_WX, 1, 0, 0, R_BY, 0);
         6'd38: s = mk(PH_FOLD, R_TY, R_WY, 0, 0, 0, R_BY, 0);
         6'd39: s = mk(PH_FOLD, R_UY, R_WZ, 0, 0, 1, R_BY, 0);
         6'd40: s = mk(PH_FOLD, R_NZ, R_WX, 1, 0, 0, R_BZ, 0);
         6'd41: s = mk(PH_FOLD, R_TZ, R_WY, 0, 0, 0, R_BZ, 0);
         6'd42: s = mk(PH_FOLD, R_UZ, R_WZ, 0, 0, 1, R_BZ, 0);
         6'd43: s = mk(PH_FOLD, R_AX, R_BX, 1, 0, 1, R_C0, 0);
         6'd44: s = mk(PH_FOLD, R_AY, R_BY, 1, 0, 1, R_C1, 0);
         6'd45: s = mk(PH_FOLD, R_AZ, R_BZ, 1, 0, 1, R_C2, 0);
         6'd46: s = mk(PH_FOLD, R_NX, R_C0, 1, 0, 0, R_WX, 0);
         6'd47: s = mk(PH_FOLD, R_NY, R_C1, 0, 0, 0, R_WX, 0);
         6'd48: s = mk(PH_FOLD, R_NZ, R_C2, 0, 0, 1, R_WX, 0);
         6'd49: s = mk(PH_FOLD, R_ZERO, R_ZERO, 0, 0, 0, R_WX, 0);
         6'd50: s = mk(PH_FOLD, R_TX, R_C0, 1, 0, 0, R_WY, 0);
         6'd51: s = mk(PH_FOLD, R_TY, R_C1, 0, 0, 0, R_WY, 0);
         6'd52: s = mk(PH_FOLD, R_TZ, R_C2, 0, 0, 1, R_WY, 0);
         6'd53: s = mk(PH_FOLD, R_UX, R_C0, 1, 0, 0, R_WZ, 0);
         6'd54: s = mk(PH_FOLD, R_UY, R_C1, 0, 0, 0, R_WZ, 0);
         6'd55: s = mk(PH_FOLD, R_UZ, R_C2, 0, 0, 1, R_WZ, 0);
         default: s = mk(PH_ALL, R_ZERO, R_ZERO, 1, 0, 0, R_ZERO, 0);
      endcase
      return s;
   endfunction

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;
endpackage
`default_nettype wire

// ----- hdl/crk_mac.sv -----
// ----------------------------------------------------------------------------
// crk_mac
// Shared multiply-accumulate unit: floor-rounded Q16.16 product, accumulated.
// ----------------------------------------------------------------------------
`default_nettype none
module crk_mac import crk_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic                 clr,
   input  wire logic                 sub,
   input  wire logic                 load,
   input  wire logic signed [QW-1:0] load_val,
   input  wire logic signed [QW-1:0] a,
   input  wire logic signed [QW-1:0] b,
   output logic signed [QW+3:0]      acc_out
);
   // A product of two Q16.16 values shifted right by 16 fits in 48 bits.
   logic signed [2*QW-1:0] prod_full;
   logic signed [QW+15:0]  prod_q;
   logic signed [QW+19:0]  acc_ff, acc_in, base;

   assign prod_full = a * b;
   assign prod_q    = prod_full[2*QW-1:16]; // arithmetic shift floors

   always_comb begin
      if (load) base = {{20{load_val[QW-1]}}, load_val};
      else if (clr) base = '0;
      else base = acc_ff;
      acc_in = sub ? base - {{4{prod_q[QW+15]}}, prod_q}
                   : base + {{4{prod_q[QW+15]}}, prod_q};
   end

   always_ff @(posedge clock) begin
      if (en) acc_ff <= acc_in;
   end

   // Saturated view of the accumulator: clip to the signed 32-bit range.
   always_comb begin
      if (acc_ff > 52'sd2147483647) acc_out = 36'sd2147483647;
      else if (acc_ff < -52'sd2147483648) acc_out = -36'sd2147483648;
      else acc_out = acc_ff[QW+3:0];
   end
endmodule
`default_nettype wire

// ----- hdl/contact_restitution_kick.sv -----
// Sequencing: a separating contact finishes once step 3 has settled its response;
// any approaching one, whatever its flags, runs to the last step, since the
// sequencer walks the whole 58-step program and disabled phases pass as idle steps.
// Throughput: one contact at a time; req_ready is low from the request transfer
// until the result transfer.
// Reset: synchronous active-high; clears the sequencer, peak byte and threshold.
// ----------------------------------------------------------------------------
// contact_restitution_kick
// Contact restitution response with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contact_restitution_kick_defines.svh"
module contact_restitution_kick import crk_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [7:0]           csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [QW-1:0] req_vel_x,
   input  wire logic signed [QW-1:0] req_vel_y,
   input  wire logic signed [QW-1:0] req_vel_z,
   input  wire logic signed [QW-1:0] req_spin_x,
   input  wire logic signed [QW-1:0] req_spin_y,
   input  wire logic signed [QW-1:0] req_spin_z,
   input  wire logic signed [QW-1:0] req_norm_x,
   input  wire logic signed [QW-1:0] req_norm_y,
   input  wire logic signed [QW-1:0] req_norm_z,
   input  wire logic                 req_extra_damp,
   input  wire logic                 req_fold_spin,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_responded,
   output logic signed [QW-1:0]      rsp_new_vel_x,
   output logic signed [QW-1:0]      rsp_new_vel_y,
   output logic signed [QW-1:0]      rsp_new_vel_z,
   output logic signed [QW-1:0]      rsp_new_spin_x,
   output logic signed [QW-1:0]      rsp_new_spin_y,
   output logic signed [QW-1:0]      rsp_new_spin_z,
   output logic                      rsp_effect_valid,
   output logic [4:0]                rsp_intensity,
   output logic [7:0]                rsp_peak_level
);
   // Register file: the working copies of the vectors and the intermediates.
   logic signed [QW-1:0] rf_ff [0:28];
   state_type state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [7:0] thr_ff, peak_ff, peak_in;
   logic damp_ff, fold_ff, resp_ff, resp_in, hit_ff, hit_in;
   logic [4:0] inten_ff, inten_in;
   step_type st;
   logic run_step, mac_en;
   logic signed [QW+3:0] acc_sat;
   logic signed [QW-1:0] op_a, op_b, acc_q, load_q, d_q;
   logic accept_in, accept_out, last_step;
   logic [QW-1:0] mag;
   logic [23:0] pk_scaled;
   logic [7:0] pk;
   // The MAC result lands in the cycle after its step; remember the pending store.
   logic wr_pend_ff;
   reg_type wr_dst_ff;

   assign st = prog(pc_ff);
   assign accept_in  = req_valid && req_ready;
   assign accept_out = rsp_valid && rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign last_step  = (pc_ff == PC_W'(NSTEP - 1));

   // A step runs if its phase is enabled for this contact; after step 3 a
   // separating contact skips everything, since resp_ff is then settled.
   always_comb begin
      unique case (st.ph)
         PH_ALL:  run_step = 1'b1;
         PH_HIT:  run_step = resp_ff && hit_ff;
         PH_DAMP: run_step = resp_ff && damp_ff;
         PH_FOLD: run_step = resp_ff && fold_ff;
         default: run_step = 1'b0;
      endcase
      if (pc_ff > PC_W'(3) && !resp_ff) run_step = 1'b0;
   end

   // A register whose store is still pending is read straight from the
   // accumulator, so a step may use the result of the step just before it.
   assign op_a   = (wr_pend_ff && wr_dst_ff == st.a) ? acc_q : rf_ff[st.a];
   assign op_b   = (wr_pend_ff && wr_dst_ff == st.b) ? acc_q : rf_ff[st.b];
   assign load_q = (wr_pend_ff && wr_dst_ff == st.dst) ? acc_q : rf_ff[st.dst];
   assign d_q    = (wr_pend_ff && wr_dst_ff == R_D) ? acc_q : rf_ff[R_D];
   assign mac_en = (state_ff == ST_RUN) && run_step;

   crk_mac u_mac (
      .clock    (clock),
      .en       (mac_en),
      .clr      (st.clr),
      .sub      (st.sub),
      .load     (st.add_dst),
      .load_val (load_q),
      .a        (op_a),
      .b        (op_b),
      .acc_out  (acc_sat)
   );
   assign acc_q = acc_sat[QW-1:0];

   always_ff @(posedge clock) begin
      wr_pend_ff <= mac_en && st.store;
      wr_dst_ff  <= st.dst;
      if (reset) wr_pend_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         rf_ff[R_VX] <= req_vel_x;  rf_ff[R_VY] <= req_vel_y;
         rf_ff[R_VZ] <= req_vel_z;  rf_ff[R_WX] <= req_spin_x;
         rf_ff[R_WY] <= req_spin_y; rf_ff[R_WZ] <= req_spin_z;
         rf_ff[R_NX] <= req_norm_x; rf_ff[R_NY] <= req_norm_y;
         rf_ff[R_NZ] <= req_norm_z;
         rf_ff[R_K]    <= KICK_Q;
         rf_ff[R_DAMP] <= DAMP_Q;
         rf_ff[R_ZERO] <= '0;
         damp_ff <= req_extra_damp;
         fold_ff <= req_fold_spin;
      end else if (wr_pend_ff) begin
         rf_ff[wr_dst_ff] <= acc_q;
      end
   end

   // Intensity from the dot product, available while step 3 runs. The peak
   // byte divides by 27 through a reciprocal multiply, 4855 / 2^17, which is
   // exact for every intensity from 0 to 27.
   always_comb begin
      mag = -d_q;
      if (d_q == {1'b1, {(QW-1){1'b0}}} || mag > QW'(INTEN_MAX * 65536))
         inten_in = 5'(INTEN_MAX);
      else
         inten_in = mag[20:16];
      pk_scaled = {12'd0, 12'd127 * {7'd0, inten_in}} * 24'd4855;
      pk = 8'd128 + {1'b0, pk_scaled[23:17]};
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      resp_in  = resp_ff;
      hit_in   = hit_ff;
      peak_in  = peak_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pc_in = '0;
            if (accept_in) state_in = ST_RUN;
         end
         ST_RUN: begin
            pc_in = pc_ff + PC_W'(1);
            if (pc_ff == PC_W'(3)) begin
               resp_in = d_q[QW-1];
               hit_in  = d_q[QW-1] && (thr_ff >= THRESH_MIN);
               if (d_q[QW-1] && (thr_ff >= THRESH_MIN) && pk > peak_ff)
                  peak_in = pk;
            end
            if (last_step || (pc_ff > PC_W'(3) && !resp_ff)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (accept_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         peak_ff  <= '0;
         thr_ff   <= '0;
         resp_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         peak_ff  <= peak_in;
         resp_ff  <= resp_in;
         hit_ff   <= hit_in;
         if (csr_we) thr_ff <= csr_wdata;
      end
      if (pc_ff == PC_W'(3) && state_ff == ST_RUN) inten_ff <= inten_in;
   end

   assign rsp_responded    = resp_ff;
   assign rsp_new_vel_x    = rf_ff[R_VX];
   assign rsp_new_vel_y    = rf_ff[R_VY];
   assign rsp_new_vel_z    = rf_ff[R_VZ];
   assign rsp_new_spin_x   = rf_ff[R_WX];
   assign rsp_new_spin_y   = rf_ff[R_WY];
   assign rsp_new_spin_z   = rf_ff[R_WZ];
   assign rsp_effect_valid = hit_ff;
   assign rsp_intensity    = hit_ff ? inten_ff : 5'd0;
   assign rsp_peak_level   = peak_ff;

   `CRK_ASSERT(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready while result waits")
   `CRK_ASSERT(a_peak_mono, clock, reset, (state_ff != ST_IDLE) |=> (peak_ff >= $past(peak_ff)), "peak fell")
   `CRK_ASSERT(a_hit_resp, clock, reset, hit_ff |-> resp_ff, "effect without response")
endmodule
`default_nettype wire
